// ===== hdl/sfh_pkg.sv =====
`default_nettype none

package sfh_pkg;

  // Field widths.
  localparam int unsigned ByteW   = 8;
  localparam int unsigned TriesW  = 4;
  localparam int unsigned TicksW  = 16;
  localparam int unsigned CfgW    = 16;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned PosW    = 3;

  // Frame bytes and control codes.
  localparam logic [ByteW-1:0] FLAG_BYTE = 8'h7e;
  localparam logic [ByteW-1:0] CTRL_SET  = 8'h03;
  localparam logic [ByteW-1:0] CTRL_UA   = 8'h07;
  localparam logic [ByteW-1:0] CTRL_DISC = 8'h0b;

  // Frame positions.
  localparam logic [PosW-1:0] POS_FIRST = 3'd0;
  localparam logic [PosW-1:0] POS_ADDR  = 3'd1;
  localparam logic [PosW-1:0] POS_CTRL  = 3'd2;
  localparam logic [PosW-1:0] POS_CHECK = 3'd3;
  localparam logic [PosW-1:0] POS_LAST  = 3'd4;
  localparam logic [PosW-1:0] FRAME_LEN = 3'd5;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] REG_ADDRESS   = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_MAX_TRIES = 2'd1;
  localparam logic [CfgIdxW-1:0] REG_TIMEOUT   = 2'd2;

  // Configuration reset values.
  localparam logic [ByteW-1:0]  RST_ADDRESS   = 8'd3;
  localparam logic [TriesW-1:0] RST_MAX_TRIES = 4'd3;
  localparam logic [TicksW-1:0] RST_TIMEOUT   = 16'd3;

  typedef enum logic [1:0] {
    FUNC_CONNECT,
    FUNC_DISCONNECT,
    FUNC_RX,
    FUNC_TICK
  } func_e;

  typedef enum logic [1:0] {
    KIND_TX,
    KIND_OK,
    KIND_FAIL,
    KIND_NONE
  } kind_e;

  typedef struct packed {
    func_e            func;
    logic [ByteW-1:0] rx_byte;
  } in_t;

  typedef struct packed {
    kind_e            kind;
    logic [ByteW-1:0] tx_byte;
    logic             last;
  } out_t;

  // Result descriptor handed from the protocol controller to the emitter.
  typedef struct packed {
    logic             is_frame;
    kind_e            kind;
    logic [ByteW-1:0] addr;
    logic [ByteW-1:0] ctrl;
  } desc_t;

  // Byte at a given position of a supervisory frame.
  function automatic logic [ByteW-1:0] frame_byte(logic [PosW-1:0]  pos,
                                                  logic [ByteW-1:0] addr,
                                                  logic [ByteW-1:0] ctrl);
    logic [ByteW-1:0] b;
    case (pos)
      POS_ADDR:  b = addr;
      POS_CTRL:  b = ctrl;
      POS_CHECK: b = addr ^ ctrl;
      default:   b = FLAG_BYTE;
    endcase
    return b;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/sfh_ctrl.sv =====
`default_nettype none

module sfh_ctrl (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         cfg_we_i,
  input  wire logic [sfh_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [sfh_pkg::CfgW-1:0]     cfg_data_i,
  input  wire logic                         in_valid_i,
  output logic                              in_stall_o,
  input  wire sfh_pkg::in_t                 in_data_i,
  input  wire logic                         pop_i,
  output logic                              desc_valid_o,
  output sfh_pkg::desc_t                    desc_o
);

  logic [sfh_pkg::ByteW-1:0]  addr_q;
  logic [sfh_pkg::TriesW-1:0] max_tries_q;
  logic [sfh_pkg::TicksW-1:0] timeout_q;

  logic                       waiting_q, waiting_d;
  logic                       disc_q, disc_d;
  logic [sfh_pkg::PosW-1:0]   match_q, match_d;
  logic [sfh_pkg::TicksW-1:0] tick_q, tick_d;
  logic [sfh_pkg::TriesW-1:0] tries_q, tries_d;

  logic                       a_valid_q;
  sfh_pkg::desc_t             a_q, desc_d;
  logic                       in_fire;

  logic [sfh_pkg::PosW-1:0]   idx, idx_n;
  logic [sfh_pkg::ByteW-1:0]  rx_ctrl, tx_ctrl;
  logic [sfh_pkg::TicksW-1:0] tick_n, limit;
  logic [sfh_pkg::TriesW-1:0] tries_dec;

  // The descriptor register takes a new transfer when empty or when it drains.
  assign in_stall_o = a_valid_q && !pop_i;
  assign in_fire    = in_valid_i && !in_stall_o;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      addr_q      <= sfh_pkg::RST_ADDRESS;
      max_tries_q <= sfh_pkg::RST_MAX_TRIES;
      timeout_q   <= sfh_pkg::RST_TIMEOUT;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        sfh_pkg::REG_ADDRESS:   addr_q      <= cfg_data_i[sfh_pkg::ByteW-1:0];
        sfh_pkg::REG_MAX_TRIES: max_tries_q <= cfg_data_i[sfh_pkg::TriesW-1:0];
        sfh_pkg::REG_TIMEOUT:   timeout_q   <= cfg_data_i[sfh_pkg::TicksW-1:0];
        default: ;
      endcase
    end
  end

  // Shared terms for matching and timing.
  always_comb begin
    rx_ctrl   = disc_q ? sfh_pkg::CTRL_DISC : sfh_pkg::CTRL_UA;
    tx_ctrl   = disc_q ? sfh_pkg::CTRL_DISC : sfh_pkg::CTRL_SET;
    idx       = (match_q < sfh_pkg::FRAME_LEN) ? match_q : sfh_pkg::POS_FIRST;
    if (in_data_i.rx_byte == sfh_pkg::frame_byte(idx, addr_q, rx_ctrl)) begin
      idx_n = idx + 3'd1;
    end else if (in_data_i.rx_byte == sfh_pkg::FLAG_BYTE) begin
      idx_n = sfh_pkg::POS_ADDR;
    end else begin
      idx_n = sfh_pkg::POS_FIRST;
    end
    tick_n    = tick_q + 16'd1;
    limit     = (timeout_q != '0) ? timeout_q : 16'd1;
    tries_dec = (tries_q != '0) ? tries_q - 4'd1 : '0;
  end

  // Protocol state update and result descriptor for one input transfer.
  always_comb begin
    waiting_d       = waiting_q;
    disc_d          = disc_q;
    match_d         = match_q;
    tick_d          = tick_q;
    tries_d         = tries_q;
    desc_d.is_frame = 1'b0;
    desc_d.kind     = sfh_pkg::KIND_NONE;
    desc_d.addr     = addr_q;
    desc_d.ctrl     = tx_ctrl;
    if (in_data_i.func inside {sfh_pkg::FUNC_CONNECT, sfh_pkg::FUNC_DISCONNECT}) begin
      disc_d          = (in_data_i.func == sfh_pkg::FUNC_DISCONNECT);
      tries_d         = (max_tries_q != '0) ? max_tries_q : 4'd1;
      waiting_d       = 1'b1;
      match_d         = sfh_pkg::POS_FIRST;
      tick_d          = '0;
      desc_d.is_frame = 1'b1;
      desc_d.kind     = sfh_pkg::KIND_TX;
      desc_d.ctrl     = disc_d ? sfh_pkg::CTRL_DISC : sfh_pkg::CTRL_SET;
    end else if (waiting_q) begin
      if (in_data_i.func == sfh_pkg::FUNC_RX) begin
        if (idx_n >= sfh_pkg::FRAME_LEN) begin
          waiting_d   = 1'b0;
          match_d     = sfh_pkg::POS_FIRST;
          tick_d      = '0;
          desc_d.kind = sfh_pkg::KIND_OK;
        end else begin
          match_d = idx_n;
        end
      end else if (tick_n < limit) begin
        tick_d = tick_n;
      end else begin
        // Timeout: one try is used, then resend or give up.
        tick_d  = '0;
        match_d = sfh_pkg::POS_FIRST;
        tries_d = tries_dec;
        if (tries_dec == '0) begin
          waiting_d   = 1'b0;
          desc_d.kind = sfh_pkg::KIND_FAIL;
        end else begin
          desc_d.is_frame = 1'b1;
          desc_d.kind     = sfh_pkg::KIND_TX;
        end
      end
    end
  end

  // Protocol state registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      waiting_q <= 1'b0;
      disc_q    <= 1'b0;
      match_q   <= '0;
      tick_q    <= '0;
      tries_q   <= '0;
    end else if (in_fire) begin
      waiting_q <= waiting_d;
      disc_q    <= disc_d;
      match_q   <= match_d;
      tick_q    <= tick_d;
      tries_q   <= tries_d;
    end
  end

  // Descriptor register valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
    end else if (in_fire) begin
      a_valid_q <= 1'b1;
    end else if (pop_i) begin
      a_valid_q <= 1'b0;
    end
  end

  // Descriptor payload.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      a_q <= desc_d;
    end
  end

  assign desc_valid_o = a_valid_q;
  assign desc_o       = a_q;

endmodule

`default_nettype wire

// ===== hdl/sfh_emit.sv =====
`default_nettype none

module sfh_emit (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           desc_valid_i,
  input  wire sfh_pkg::desc_t desc_i,
  output logic                pop_o,
  output logic                out_valid_o,
  input  wire logic           out_stall_i,
  output sfh_pkg::out_t       out_data_o
);

  logic                     b_valid_q;
  sfh_pkg::desc_t           b_q;
  logic [sfh_pkg::PosW-1:0] pos_q;
  logic                     out_fire, b_done;

  // Current result from the held descriptor and frame position.
  always_comb begin
    if (b_q.is_frame) begin
      out_data_o.kind    = sfh_pkg::KIND_TX;
      out_data_o.tx_byte = sfh_pkg::frame_byte(pos_q, b_q.addr, b_q.ctrl);
      out_data_o.last    = (pos_q == sfh_pkg::POS_LAST);
    end else begin
      out_data_o.kind    = b_q.kind;
      out_data_o.tx_byte = '0;
      out_data_o.last    = 1'b1;
    end
  end

  assign out_valid_o = b_valid_q;
  assign out_fire    = b_valid_q && !out_stall_i;
  assign b_done      = out_fire && out_data_o.last;
  assign pop_o       = desc_valid_i && (!b_valid_q || b_done);

  // Sequencer control: one result per output transfer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q <= 1'b0;
      pos_q     <= sfh_pkg::POS_FIRST;
    end else if (pop_o) begin
      b_valid_q <= 1'b1;
      pos_q     <= sfh_pkg::POS_FIRST;
    end else if (b_done) begin
      b_valid_q <= 1'b0;
    end else if (out_fire) begin
      pos_q <= pos_q + 3'd1;
    end
  end

  // Held descriptor.
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      b_q <= desc_i;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/supervisory_frame_handshake.sv =====
// An item's first result is registered in sfh_ctrl, then in sfh_emit. Throughput,
// unless the output stalls: an item with one result can be taken every cycle; a
// start or a resend holds the output sequencer for a five-byte frame, one frame byte
// per cycle. Reset (rst_ni low, asynchronous) clears the link state to idle, empties
// both stages and loads address 3, three tries and a timeout of three ticks.
`default_nettype none

module supervisory_frame_handshake (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         cfg_we_i,
  input  wire logic [sfh_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [sfh_pkg::CfgW-1:0]     cfg_data_i,
  input  wire logic                         in_valid_i,
  output logic                              in_stall_o,
  input  wire sfh_pkg::in_t                 in_data_i,
  output logic                              out_valid_o,
  input  wire logic                         out_stall_i,
  output sfh_pkg::out_t                     out_data_o
);

  logic           desc_valid;
  sfh_pkg::desc_t desc;
  logic           pop;

  // Protocol state and result descriptor stage.
  sfh_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .in_data_i    (in_data_i),
    .pop_i        (pop),
    .desc_valid_o (desc_valid),
    .desc_o       (desc)
  );

  // Output register and frame byte sequencer.
  sfh_emit u_emit (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .desc_valid_i (desc_valid),
    .desc_i       (desc),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_data_o   (out_data_o)
  );

endmodule

`default_nettype wire

// ===== hdl/sfh_checker.sv =====
`default_nettype none

module sfh_checker (
  input wire logic                         clk_i,
  input wire logic                         rst_ni,
  input wire logic                         out_valid_o,
  input wire logic                         out_stall_i,
  input wire sfh_pkg::out_t                out_data_o
);

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed");

  // Frame bytes follow one another without a gap.
  a_frame_burst: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && !out_data_o.last |=> out_valid_o)
    else $error("gap inside a frame");

  // Status results are single and carry no byte.
  a_status_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.kind != sfh_pkg::KIND_TX
      |-> out_data_o.last && out_data_o.tx_byte == '0)
    else $error("malformed status result");

  // Every frame closes with a flag.
  a_frame_close: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.kind == sfh_pkg::KIND_TX && out_data_o.last
      |-> out_data_o.tx_byte == sfh_pkg::FLAG_BYTE)
    else $error("frame does not end with a flag");

endmodule

bind supervisory_frame_handshake sfh_checker u_sfh_checker (.*);

`default_nettype wire
